>>> sv/hfd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman decoder package
// Shared sizes, codes and structures of the tree load and decode unit.
// ----------------------------------------------------------------------------
package hfd_pkg;

  localparam int unsigned MaxNodes   = 511;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned NodeAw     = $clog2(MaxNodes);
  localparam int unsigned NcW        = $clog2(MaxNodes + 1) + 1;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned KeyW       = 8;
  localparam int unsigned KeyBits    = 8;
  localparam int unsigned KblW       = 4;
  localparam int unsigned CfgW       = 32;
  localparam int unsigned PaddrW     = 3;

  // Request types.
  localparam logic REQ_TREE = 1'b0;
  localparam logic REQ_CODE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_SYMBOL   = 2'd0;
  localparam logic [1:0] STATUS_LOADED   = 2'd1;
  localparam logic [1:0] STATUS_NO_TREE  = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  // Register index of code_bit_count.
  localparam logic REG_CODE_BIT_COUNT = 1'b0;

  typedef struct packed {
    logic req_type;
    logic bit_value;
  } in_req_t;

  typedef struct packed {
    logic [KeyW-1:0] symbol;
    logic [1:0]      status;
  } out_rsp_t;

  // One node entry: a leaf keeps its key in the low bits of left.
  typedef struct packed {
    logic              leaf;
    logic [NodeAw-1:0] right;
    logic [NodeAw-1:0] left;
  } node_t;

  typedef struct packed {
    logic              en;
    logic [NodeAw-1:0] addr;
    node_t             data;
  } node_wr_t;

  typedef struct packed {
    logic       emit;
    logic       done;
    logic [1:0] status;
  } load_evt_t;

  // What an accepted request leaves for the result stage.
  typedef struct packed {
    logic            emit;
    logic            lookup;
    logic [KeyW-1:0] symbol;
    logic [1:0]      status;
  } stage_t;

  typedef struct packed {
    logic            leaf;
    logic [KeyW-1:0] key;
  } rd_info_t;

endpackage

>>> sv/hfd_loader.sv
// ----------------------------------------------------------------------------
// Tree loader
// Rebuilds the tree from preorder tree bits, keeps the pending-node stack.
// ----------------------------------------------------------------------------
module hfd_loader (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tree_fire_i,
  input  logic              bit_i,
  output hfd_pkg::node_wr_t node_wr_o,
  output hfd_pkg::load_evt_t evt_o,
  output logic              tree_ready_o
);
  import hfd_pkg::*;

  logic [NodeAw-1:0]  stack_mem [StackDepth];
  logic [NodeAw-1:0]  stack_rd_q;

  logic [NcW-1:0]     nc_q, nc_d, nc_s;
  logic [SpW-1:0]     sp_q, sp_d, sp_s, pop_idx;
  logic [NodeAw-1:0]  cur_q, cur_d, cur_s, cur_eff;
  logic               pop_pend_q, pop_pend_d;
  logic [KblW-1:0]    kbl_q, kbl_d, kbl_s;
  logic [KeyW-1:0]    key_q, key_d, key_s, key_n;
  logic               ready_q, ready_d;
  logic               active;
  logic               overflow;
  logic               push_en, pop_en;
  logic [StackAw-1:0] push_addr, pop_addr;
  logic [NodeAw-1:0]  push_data;

  assign cur_eff = pop_pend_q ? stack_rd_q : cur_q;
  assign active  = (nc_q != '0);

  // A tree bit with no load in progress starts a fresh load at the root.
  assign nc_s  = active ? nc_q : NcW'(1);
  assign sp_s  = active ? sp_q : '0;
  assign kbl_s = active ? kbl_q : '0;
  assign key_s = active ? key_q : '0;
  assign cur_s = active ? cur_eff : '0;

  assign key_n    = {key_s[KeyW-2:0], bit_i};
  assign pop_idx  = sp_s - SpW'(1);
  assign overflow = (({1'b0, nc_s} + (NcW + 1)'(2)) > (NcW + 1)'(MaxNodes)) ||
                    (sp_s >= SpW'(StackDepth));

  always_comb begin
    nc_d       = nc_q;
    sp_d       = sp_q;
    cur_d      = cur_eff;
    pop_pend_d = 1'b0;
    kbl_d      = kbl_q;
    key_d      = key_q;
    ready_d    = ready_q;
    node_wr_o  = '0;
    evt_o      = '0;
    push_en    = 1'b0;
    push_addr  = sp_s[StackAw-1:0];
    push_data  = nc_s[NodeAw-1:0];
    pop_en     = 1'b0;
    pop_addr   = pop_idx[StackAw-1:0];
    if (tree_fire_i) begin
      nc_d    = nc_s;
      sp_d    = sp_s;
      cur_d   = cur_s;
      kbl_d   = kbl_s;
      key_d   = key_s;
      ready_d = 1'b0;
      if (kbl_s != '0) begin
        key_d = key_n;
        kbl_d = kbl_s - KblW'(1);
        if (kbl_s == KblW'(1)) begin
          node_wr_o.en        = 1'b1;
          node_wr_o.addr      = cur_s;
          node_wr_o.data.leaf = 1'b1;
          node_wr_o.data.left = NodeAw'(key_n);
          if (sp_s == '0) begin
            ready_d      = 1'b1;
            nc_d         = '0;
            cur_d        = '0;
            evt_o.emit   = 1'b1;
            evt_o.done   = 1'b1;
            evt_o.status = STATUS_LOADED;
          end else begin
            sp_d       = pop_idx;
            pop_en     = 1'b1;
            pop_pend_d = 1'b1;
          end
        end
      end else if (bit_i) begin
        kbl_d = KblW'(KeyBits);
        key_d = '0;
      end else if (overflow) begin
        nc_d         = '0;
        sp_d         = '0;
        kbl_d        = '0;
        key_d        = '0;
        cur_d        = '0;
        evt_o.emit   = 1'b1;
        evt_o.status = STATUS_OVERFLOW;
      end else begin
        node_wr_o.en         = 1'b1;
        node_wr_o.addr       = cur_s;
        node_wr_o.data.left  = nc_s[NodeAw-1:0];
        node_wr_o.data.right = NodeAw'(nc_s + NcW'(1));
        push_en              = 1'b1;
        sp_d                 = sp_s + SpW'(1);
        cur_d                = NodeAw'(nc_s + NcW'(1));
        nc_d                 = nc_s + NcW'(2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[push_addr] <= push_data;
    end
    if (pop_en) begin
      stack_rd_q <= stack_mem[pop_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q       <= '0;
      sp_q       <= '0;
      cur_q      <= '0;
      pop_pend_q <= 1'b0;
      kbl_q      <= '0;
      key_q      <= '0;
      ready_q    <= 1'b0;
    end else begin
      nc_q       <= nc_d;
      sp_q       <= sp_d;
      cur_q      <= cur_d;
      pop_pend_q <= pop_pend_d;
      kbl_q      <= kbl_d;
      key_q      <= key_d;
      ready_q    <= ready_d;
    end
  end

  assign tree_ready_o = ready_q;

  a_ready_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (nc_q == '0))
    else $error("tree marked ready while a load is in progress");

  a_kbl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kbl_q <= KblW'(KeyBits))
    else $error("key bit counter out of range");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q <= SpW'(StackDepth)) && ((nc_q != '0) || (sp_q == '0)))
    else $error("pending stack pointer out of range");

endmodule

>>> sv/hfd_walker.sv
// ----------------------------------------------------------------------------
// Tree walker
// Holds the node memory and walks it one code bit per cycle while the input is not stalled.
// ----------------------------------------------------------------------------
module hfd_walker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     code_fire_i,
  input  logic                     bit_i,
  input  logic                     tree_ready_i,
  input  logic                     load_done_i,
  input  hfd_pkg::node_wr_t        node_wr_i,
  input  logic [hfd_pkg::CfgW-1:0] code_bit_count_i,
  output hfd_pkg::stage_t          res_o,
  output hfd_pkg::rd_info_t        rd_o
);
  import hfd_pkg::*;

  node_t             node_mem [MaxNodes];
  node_t             node_rd_q;
  node_t             cur_entry_q, cur_entry_d;
  node_t             root_entry_q, root_entry_d;
  node_t             eff;
  logic              lookup_pend_q, lookup_pend_d;
  logic [CfgW-1:0]   seen_q, seen_d;
  logic              rd_en;
  logic [NodeAw-1:0] rd_addr;

  // The entry of the current node: a finished lookup that hit a leaf
  // sends the walk back to the root.
  always_comb begin
    if (lookup_pend_q) begin
      eff = node_rd_q.leaf ? root_entry_q : node_rd_q;
    end else begin
      eff = cur_entry_q;
    end
  end

  assign root_entry_d = (node_wr_i.en && (node_wr_i.addr == '0)) ? node_wr_i.data
                                                                 : root_entry_q;
  assign rd_addr = bit_i ? eff.right : eff.left;

  always_comb begin
    cur_entry_d   = eff;
    lookup_pend_d = 1'b0;
    seen_d        = seen_q;
    rd_en         = 1'b0;
    res_o         = '0;
    if (load_done_i) begin
      cur_entry_d = root_entry_d;
      seen_d      = '0;
    end
    if (code_fire_i) begin
      if (!tree_ready_i) begin
        res_o.emit   = 1'b1;
        res_o.status = STATUS_NO_TREE;
      end else if (seen_q < code_bit_count_i) begin
        seen_d = seen_q + CfgW'(1);
        if (eff.leaf) begin
          res_o.emit   = 1'b1;
          res_o.symbol = eff.left[KeyW-1:0];
          res_o.status = STATUS_SYMBOL;
        end else begin
          rd_en         = 1'b1;
          lookup_pend_d = 1'b1;
          res_o.lookup  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_wr_i.en) begin
      node_mem[node_wr_i.addr] <= node_wr_i.data;
    end
    if (rd_en) begin
      node_rd_q <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_entry_q   <= '0;
      root_entry_q  <= '0;
      lookup_pend_q <= 1'b0;
      seen_q        <= '0;
    end else begin
      cur_entry_q   <= cur_entry_d;
      root_entry_q  <= root_entry_d;
      lookup_pend_q <= lookup_pend_d;
      seen_q        <= seen_d;
    end
  end

  assign rd_o.leaf = node_rd_q.leaf;
  assign rd_o.key  = node_rd_q.left[KeyW-1:0];

  a_done_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_done_i |=> (!lookup_pend_q && (cur_entry_q == root_entry_q)))
    else $error("walk does not restart at the root after a tree load");

endmodule

>>> sv/huffman_tree_load_and_decode_unit.sv
// ----------------------------------------------------------------------------
// Huffman tree load and decode unit
// Loads a Huffman tree from preorder tree bits and decodes code bits with it.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                   | Payload
//   --------+-----------+-----------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o     | in_req_i  (req_type, bit_value)
//   out     | output    | out_valid_o / out_stall_i   | out_rsp_o (symbol, status)
//   cfg     | input     | psel/penable/pwrite, pready | code_bit_count at byte 0
//
// One request is taken every cycle while the input is not stalled, tree bits
// and code bits alike. A code bit's child address comes straight from the
// node memory's registered read data, so that read loop sets the rate. A
// result passes through the result stage and then the output register. Reset
// takes effect at once and needs no clearing pass: the node memory and the
// pending stack are only read where the load has written them. A stall on
// the output fills the result stage and then stalls the input.
//
module huffman_tree_load_and_decode_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hfd_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hfd_pkg::out_rsp_t          out_rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hfd_pkg::PaddrW-1:0] paddr,
  input  logic [hfd_pkg::CfgW-1:0]   pwdata,
  output logic [hfd_pkg::CfgW-1:0]   prdata,
  output logic                       pready
);
  import hfd_pkg::*;

  // Configuration register. The word index is paddr[2]; the low bits are
  // the byte offset and are not decoded.
  logic [CfgW-1:0] code_bit_count_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CODE_BIT_COUNT);
  assign prdata = (paddr[2] == REG_CODE_BIT_COUNT) ? code_bit_count_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bit_count_q <= '0;
    end else if (cfg_wr) begin
      code_bit_count_q <= pwdata;
    end
  end

  // Request acceptance. The result stage drains whenever the output
  // register is empty or being taken, and the input only stalls when the
  // result stage is occupied and cannot drain.
  logic out_free;
  logic accept;
  logic tree_fire;
  logic code_fire;

  logic s1_valid_q, s1_valid_d;
  stage_t s1_q;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign tree_fire  = accept && (in_req_i.req_type == REQ_TREE);
  assign code_fire  = accept && (in_req_i.req_type == REQ_CODE);

  node_wr_t  node_wr;
  load_evt_t load_evt;
  logic      tree_ready;
  stage_t    walk_res;
  rd_info_t  rd_info;

  hfd_loader u_loader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tree_fire_i  (tree_fire),
    .bit_i        (in_req_i.bit_value),
    .node_wr_o    (node_wr),
    .evt_o        (load_evt),
    .tree_ready_o (tree_ready)
  );

  hfd_walker u_walker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .code_fire_i      (code_fire),
    .bit_i            (in_req_i.bit_value),
    .tree_ready_i     (tree_ready),
    .load_done_i      (load_evt.done),
    .node_wr_i        (node_wr),
    .code_bit_count_i (code_bit_count_q),
    .res_o            (walk_res),
    .rd_o             (rd_info)
  );

  // Result stage: every accepted request passes through it in order. A
  // code bit that needed a child lookup resolves here from the node
  // memory's read data; it emits a symbol only when the child is a leaf.
  stage_t s1_in;

  always_comb begin
    if (in_req_i.req_type == REQ_TREE) begin
      s1_in        = '0;
      s1_in.emit   = load_evt.emit;
      s1_in.status = load_evt.status;
    end else begin
      s1_in = walk_res;
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  logic     s1_emits;
  out_rsp_t s1_rsp;

  assign s1_emits      = s1_q.emit || (s1_q.lookup && rd_info.leaf);
  assign s1_rsp.symbol = s1_q.lookup ? rd_info.key : s1_q.symbol;
  assign s1_rsp.status = s1_q.lookup ? STATUS_SYMBOL : s1_q.status;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_in;
    end
    if (out_free && s1_valid_q && s1_emits) begin
      out_rsp_o <= s1_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (out_free) begin
        out_valid_o <= s1_valid_q && s1_emits;
      end
    end
  end

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_stall_o) |=> s1_valid_q)
    else $error("result stage dropped a request while the output was stalled");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Huffman tree load and decode unit testbench
// Sends tree and code bit requests with random gaps, stalls the result side,
// and checks every result against a built-in model of the tree and the walk.
// ----------------------------------------------------------------------------
module testbench;

  import hfd_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned LimitCycles = 1000000;
  // Requests that give no result can still be in flight in the result stage or
  // the output register after the last result; this wait covers them.
  localparam int unsigned IdleCycles  = 8;
  localparam int unsigned RandomReqs  = 700;
  localparam logic [PaddrW-1:0] CodeBitCountAddr = PaddrW'({REG_CODE_BIT_COUNT, 2'b00});

  // Receiver behavior between long hold-offs.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_rsp_t          out_rsp_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [CfgW-1:0]   pwdata      = '0;
  logic [CfgW-1:0]   prdata;
  logic              pready;

  huffman_tree_load_and_decode_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model. It mirrors the unit's tree memory, the stack of left
  // children still to be described, and the position of the code walk.
  // --------------------------------------------------------------------------
  node_t             tree_mem   [MaxNodes];
  logic [NodeAw-1:0] left_stack [StackDepth];
  int unsigned       stack_fill   = 0;
  int unsigned       nodes_used   = 0;   // zero while no load is in progress
  logic [NodeAw-1:0] walk_node    = '0;
  int unsigned       key_left     = 0;
  logic [KeyW-1:0]   key_acc      = '0;
  bit                have_tree    = 1'b0;
  logic [CfgW-1:0]   bits_decoded = '0;
  logic [CfgW-1:0]   code_limit   = '0;  // mirrors code_bit_count

  // Expected results in request order, and bookkeeping for the run.
  out_rsp_t    decode_results_q [$];
  int unsigned fail_count    = 0;
  int unsigned accepted_reqs = 0;  // requests that were not padding

  function automatic void drop_load();
    nodes_used = 0;
    stack_fill = 0;
    key_left   = 0;
    key_acc    = '0;
    walk_node  = '0;
    have_tree  = 1'b0;
  endfunction

  // Applies one request to the model. Returns 1 when it gives a result.
  function automatic bit decode_step(input in_req_t req, output out_rsp_t rsp,
                                     output bit padding);
    node_t             ent;
    logic [NodeAw-1:0] nxt;
    rsp     = '0;
    padding = 1'b0;
    if (req.req_type == REQ_TREE) begin
      // A tree bit with no load in progress throws the old tree away and
      // describes the root of a new one.
      if (nodes_used == 0) begin
        drop_load();
        nodes_used = 1;
      end
      if (key_left != 0) begin
        key_acc  = {key_acc[KeyW-2:0], req.bit_value};
        key_left = key_left - 1;
        if (key_left != 0) return 1'b0;
        ent       = '0;
        ent.leaf  = 1'b1;
        ent.left  = NodeAw'(key_acc);
        tree_mem[walk_node] = ent;
        if (stack_fill == 0) begin
          // Last pending node described: the tree is complete.
          have_tree    = 1'b1;
          nodes_used   = 0;
          walk_node    = '0;
          bits_decoded = '0;
          rsp.status   = STATUS_LOADED;
          return 1'b1;
        end
        stack_fill = stack_fill - 1;
        walk_node  = left_stack[stack_fill];
        return 1'b0;
      end
      if (req.bit_value) begin
        key_left = KeyBits;
        key_acc  = '0;
        return 1'b0;
      end
      if (nodes_used + 2 > MaxNodes || stack_fill + 1 > StackDepth) begin
        drop_load();
        rsp.status = STATUS_OVERFLOW;
        return 1'b1;
      end
      // Internal node: the right child is described next, the left one later.
      ent.leaf  = 1'b0;
      ent.right = NodeAw'(nodes_used + 1);
      ent.left  = NodeAw'(nodes_used);
      tree_mem[walk_node]    = ent;
      left_stack[stack_fill] = NodeAw'(nodes_used);
      stack_fill = stack_fill + 1;
      walk_node  = NodeAw'(nodes_used + 1);
      nodes_used = nodes_used + 2;
      return 1'b0;
    end
    if (!have_tree) begin
      rsp.status = STATUS_NO_TREE;
      return 1'b1;
    end
    if (bits_decoded >= code_limit) begin
      padding = 1'b1;
      return 1'b0;
    end
    bits_decoded = bits_decoded + 1;
    ent = tree_mem[walk_node];
    // Only a single-leaf tree leaves the walk standing on a leaf.
    if (ent.leaf) begin
      walk_node  = '0;
      rsp.symbol = ent.left[KeyW-1:0];
      rsp.status = STATUS_SYMBOL;
      return 1'b1;
    end
    nxt = req.bit_value ? ent.right : ent.left;
    ent = tree_mem[nxt];
    if (ent.leaf) begin
      walk_node  = '0;
      rsp.symbol = ent.left[KeyW-1:0];
      rsp.status = STATUS_SYMBOL;
      return 1'b1;
    end
    walk_node = nxt;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Results are checked before the request of the same edge is
  // predicted; a request's result can never leave on its own edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_rsp_t want;
    out_rsp_t got;
    bit       padding;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_rsp_o;
        if (decode_results_q.size() == 0) begin
          $display("%0t: unexpected result, got symbol %0d status %0d",
                   $time, got.symbol, got.status);
          fail_count++;
        end else begin
          want = decode_results_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.symbol !== want.symbol) begin
            $display("%0t: symbol mismatch, expected %0d, got %0d",
                     $time, want.symbol, got.symbol);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (decode_step(in_req_i, want, padding)) decode_results_q.push_back(want);
        if (!padding) accepted_reqs++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It switches to a random stall mode after a random stretch; a
  // test can ask for a long hold-off, which this process counts down itself.
  // --------------------------------------------------------------------------
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_e    rx_mode   = RX_OPEN;
  logic [15:0] rx_pat    = '0;

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
        rx_pat    = 16'($urandom);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 25);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 75);
        default: begin
          rx_pat = {rx_pat[14:0], rx_pat[15]};
          out_stall_i <= rx_pat[0];
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Requests go out in bursts of random length; between bursts the
  // valid drops for a random gap unless gaps are switched off.
  // --------------------------------------------------------------------------
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  task automatic send_req(input logic req_type, input logic bit_value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gaps_on && gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= '{req_type: req_type, bit_value: bit_value};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drops valid and waits until every expected result is out and nothing
  // without a result can still be in flight. The first edge lets the monitor
  // record the request accepted on the edge before.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decode_results_q.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  // Register writes happen only while the unit is idle.
  task automatic write_code_bit_count(input logic [CfgW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= CodeBitCountAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    code_limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Describes a random full tree with the given number of leaves in preorder,
  // right subtree first. With mix_pct above zero, code bits are slipped in
  // between the tree bits.
  task automatic load_tree(input int unsigned leaves, input int unsigned mix_pct);
    int unsigned     open_slots;
    int unsigned     internals_left;
    bit              take_leaf;
    logic [KeyW-1:0] key;
    open_slots     = 1;
    internals_left = leaves - 1;
    while (open_slots != 0) begin
      if (mix_pct != 0 && $urandom_range(0, 99) < mix_pct)
        send_req(REQ_CODE, 1'($urandom_range(0, 1)));
      // A leaf in the last open slot would end the tree too early.
      if (internals_left == 0) take_leaf = 1'b1;
      else if (open_slots == 1) take_leaf = 1'b0;
      else take_leaf = 1'($urandom_range(0, 1));
      if (take_leaf) begin
        send_req(REQ_TREE, 1'b1);
        key = KeyW'($urandom_range(0, 255));
        for (int i = KeyW - 1; i >= 0; i--) send_req(REQ_TREE, key[i]);
        open_slots--;
      end else begin
        send_req(REQ_TREE, 1'b0);
        internals_left--;
        open_slots++;
      end
    end
  endtask

  task automatic send_code_bits(input int unsigned count);
    repeat (count) send_req(REQ_CODE, 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Code bits before any tree has been loaded are reported as such.
  task automatic test_no_tree();
    send_req(REQ_CODE, 1'b0);
    send_req(REQ_CODE, 1'b1);
    wait_idle();
  endtask

  // A root that is a leaf: every counted code bit gives its key. A code bit
  // in the middle of the load is refused without disturbing it, and the
  // third code bit after the load is padding.
  task automatic test_single_leaf();
    write_code_bit_count(32'd2);
    send_req(REQ_TREE, 1'b1);
    send_req(REQ_CODE, 1'b1);
    repeat (KeyBits) send_req(REQ_TREE, 1'b1);
    send_req(REQ_CODE, 1'b0);
    send_req(REQ_CODE, 1'b1);
    send_req(REQ_CODE, 1'b1);
    wait_idle();
  endtask

  // A count of zero turns every code bit into padding; raising it to the top
  // makes the same tree decode again, as the count of seen bits stays.
  task automatic test_count_limits();
    write_code_bit_count('0);
    send_req(REQ_CODE, 1'b0);
    wait_idle();
    write_code_bit_count('1);
    send_req(REQ_CODE, 1'b1);
    send_req(REQ_CODE, 1'b0);
    wait_idle();
  endtask

  // A chain of internal nodes runs out of node memory on its 256th marker.
  // The load is dropped, code bits are refused, and a new load works.
  task automatic test_node_overflow();
    repeat (256) send_req(REQ_TREE, 1'b0);
    send_req(REQ_CODE, 1'b1);
    load_tree(3, 0);
    send_code_bits(8);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the unit fills up and stalls its input; then the sender waits for
  // every result before going on.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    load_tree(8, 0);
    hold_req = 300;
    send_code_bits(80);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed streams: an occasional register write while idle, a
  // fresh tree, then code bits. The rest is noise and interleaved loads.
  task automatic test_random_streams();
    int unsigned target;
    int unsigned kind;
    int unsigned leaves;
    logic [CfgW-1:0] limit;
    target = accepted_reqs + RandomReqs;
    while (accepted_reqs < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(5, 30))
          send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          wait_idle();
          case ($urandom_range(0, 9))
            0:       limit = '0;
            1, 2:    limit = CfgW'($urandom_range(0, 30));
            3, 4, 5: limit = CfgW'($urandom);
            default: limit = '1;
          endcase
          write_code_bit_count(limit);
        end
        if ($urandom_range(0, 4) != 0) begin
          leaves = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 16);
          load_tree(leaves, ($urandom_range(0, 5) == 0) ? 15 : 0);
        end
        send_code_bits($urandom_range(10, 80));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_tree();
    test_single_leaf();
    test_count_limits();
    test_node_overflow();
    test_backpressure();
    test_random_streams();
    wait_idle();
    if (fail_count == 0) begin
      $display("** huffman_tree_load_and_decode_unit: PASSED **");
    end else begin
      $display("** huffman_tree_load_and_decode_unit: FAILED **");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("** huffman_tree_load_and_decode_unit: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
sv/hfd_pkg.sv
sv/hfd_loader.sv
sv/hfd_walker.sv
sv/huffman_tree_load_and_decode_unit.sv
sim/testbench.sv
